// ===== design/ssms_pkg.sv =====
`timescale 1ns / 1ps

package ssms_pkg;

    // default position width
    localparam int POS_BITS_DEF = 32;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICTURES = 2'd2;

    localparam logic [CFG_W-1:0] EXPOSURE_RST = 16'd1000;
    localparam logic [CFG_W-1:0] OFFSET_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] PICTURES_RST = 16'd5;

    // millisecond counter, saturating
    localparam int ELAPSED_W = 17;

    // operation codes
    localparam logic [2:0] OP_STEP      = 3'd0;
    localparam logic [2:0] OP_MS        = 3'd1;
    localparam logic [2:0] OP_SET_MODE  = 3'd2;
    localparam logic [2:0] OP_MARK_HOME = 3'd3;
    localparam logic [2:0] OP_MARK_END  = 3'd4;
    localparam logic [2:0] OP_RUN       = 3'd5;
    localparam logic [2:0] OP_SET_DIR   = 3'd6;

    // motor modes
    localparam logic [1:0] MOTOR_FREE     = 2'd0;
    localparam logic [1:0] MOTOR_HALT     = 2'd1;
    localparam logic [1:0] MOTOR_SHUTTLE  = 2'd2;
    localparam logic [1:0] MOTOR_RESERVED = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] arg;
    } t_in;

    typedef struct packed {
        logic               step_level;
        logic               dir_level;
        logic               shutter_active;
        logic [1:0]         motor_mode;
        logic signed [31:0] position;
        logic               seq_running;
        logic [15:0]        pictures_done;
        logic               rejected;
    } t_out;

    // shoot-move-shoot phases
    typedef enum logic [1:0] {
        PH_HOME   = 2'd0,
        PH_WAIT   = 2'd1,
        PH_EXPOSE = 2'd2,
        PH_MOVE   = 2'd3
    } t_phase;

    // top level control
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LIMIT,
        ST_OUT
    } t_state;

    // limit unit sequencer
    typedef enum logic [2:0] {
        L_IDLE,
        L_ABS,
        L_DIV,
        L_SIGN,
        L_MUL,
        L_DONE
    } t_lstate;

endpackage

// ===== design/slider_stepper_shoot_move_sequencer_core.sv =====
`timescale 1ns / 1ps

// Camera-slider stepper controller with a shoot-move-shoot sequencer. Each
// request (step tick, ms tick or command) yields exactly one result carrying
// the pin levels, mode, position and sequence status after that request. A
// request is applied as it is accepted, the sequencer steps in ST_EVAL and
// the result is valid in ST_OUT until it is taken. While the sequence is in
// its move phase and heading to the end point, the move limit is recomputed
// as end/(picture_count-1)*taken on a shared serial adder in ST_LIMIT before
// the result is valid. Only one request is in flight: o_in_stall stays high
// until the result has been taken.
module slider_stepper_shoot_move_sequencer_core
    import ssms_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_exposure, r_offset, r_pictures;
    logic [1:0]            r_mode, n_mode;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_end, n_end;
    logic                  r_head, n_head;
    logic                  r_dir, n_dir;
    logic                  r_step, n_step;
    t_phase                r_phase, n_phase;
    logic                  r_fresh, n_fresh;
    logic                  r_run, n_run;
    logic [15:0]           r_taken, n_taken;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic                  r_shutter, n_shutter;
    logic                  r_rej, n_rej;

    logic                  in_take;
    logic                  lim_start;
    logic                  lim_done;
    logic [POS_BITS-1:0]   lim_value;
    logic                  end_pos;
    logic                  head_tick;

    assign in_take = i_in_valid && (r_state == ST_IDLE);
    assign end_pos = ($signed(r_end) > 0);

    ssms_limit_unit #(
        .POS_BITS (POS_BITS)
    ) u_limit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (lim_start),
        .i_end     (r_end),
        .i_divisor (16'(r_pictures - 16'd1)),
        .i_taken   (r_taken),
        .o_done    (lim_done),
        .o_limit   (lim_value)
    );

    // request decode, sequencer step and result handshake
    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_end     = r_end;
        n_head    = r_head;
        n_dir     = r_dir;
        n_step    = r_step;
        n_phase   = r_phase;
        n_fresh   = r_fresh;
        n_run     = r_run;
        n_taken   = r_taken;
        n_elapsed = r_elapsed;
        n_shutter = r_shutter;
        n_rej     = r_rej;
        lim_start = 1'b0;
        head_tick = r_head;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_rej   = 1'b0;
                    n_state = ST_EVAL;
                    case (i_in.op)
                        OP_STEP: begin
                            if (r_mode != MOTOR_HALT) begin
                                if (r_mode == MOTOR_SHUTTLE) begin
                                    if (r_pos == '0) begin
                                        head_tick = 1'b1;
                                    end
                                    if (r_pos == r_end) begin
                                        head_tick = 1'b0;
                                    end
                                    n_head = head_tick;
                                    n_dir  = head_tick ? !end_pos : end_pos;
                                end
                                n_pos  = n_dir ? r_pos - 1'b1 : r_pos + 1'b1;
                                n_step = !r_step;
                            end
                        end
                        OP_MS: begin
                            if (r_elapsed != '1) begin
                                n_elapsed = r_elapsed + 1'b1;
                            end
                        end
                        OP_SET_MODE: begin
                            if (i_in.arg != MOTOR_RESERVED) begin
                                // travel from the start point is refused
                                if (i_in.arg == MOTOR_SHUTTLE && r_pos == '0) begin
                                    n_mode = MOTOR_HALT;
                                end else begin
                                    n_mode = i_in.arg;
                                end
                                n_run = 1'b0;
                            end
                        end
                        OP_MARK_HOME: begin
                            n_mode = MOTOR_HALT;
                            n_pos  = '0;
                        end
                        OP_MARK_END: begin
                            n_mode = MOTOR_HALT;
                            n_end  = r_pos;
                        end
                        OP_RUN: begin
                            if (i_in.arg == 2'd0) begin
                                n_run = 1'b0;
                            end else if (r_end == '0) begin
                                n_run = 1'b0;
                                n_rej = 1'b1;
                            end else begin
                                n_run   = 1'b1;
                                n_phase = PH_HOME;
                                n_fresh = 1'b1;
                            end
                        end
                        OP_SET_DIR: begin
                            n_dir = (i_in.arg != 2'd0);
                        end
                        default: begin
                            n_rej = 1'b0;
                        end
                    endcase
                end
            end
            ST_EVAL: begin
                n_state = ST_OUT;
                if (r_run) begin
                    case (r_phase)
                        PH_HOME: begin
                            if (r_fresh) begin
                                n_mode  = MOTOR_SHUTTLE;
                                n_taken = '0;
                                n_fresh = 1'b0;
                            end
                            if (r_head) begin
                                n_mode  = MOTOR_HALT;
                                n_fresh = 1'b1;
                                n_phase = PH_WAIT;
                            end
                        end
                        PH_WAIT: begin
                            if (r_fresh) begin
                                n_fresh   = 1'b0;
                                n_elapsed = '0;
                            end
                            if (n_elapsed >= ELAPSED_W'(r_offset)) begin
                                n_fresh = 1'b1;
                                n_phase = PH_EXPOSE;
                            end
                        end
                        PH_EXPOSE: begin
                            if (r_fresh) begin
                                n_fresh   = 1'b0;
                                n_shutter = 1'b1;
                                n_elapsed = '0;
                            end
                            if (n_elapsed >= ELAPSED_W'(r_exposure)) begin
                                n_shutter = 1'b0;
                                n_taken   = r_taken + 1'b1;
                                n_fresh   = 1'b1;
                                n_phase   = PH_MOVE;
                            end
                        end
                        PH_MOVE: begin
                            if (r_fresh) begin
                                n_fresh = 1'b0;
                                n_mode  = MOTOR_SHUTTLE;
                            end
                            // turned back toward the start point: sequence over
                            if (!r_head) begin
                                n_run  = 1'b0;
                                n_mode = MOTOR_HALT;
                            end else begin
                                lim_start = 1'b1;
                                n_state   = ST_LIMIT;
                            end
                        end
                        default: begin
                            n_phase = PH_HOME;
                        end
                    endcase
                end
            end
            ST_LIMIT: begin
                if (lim_done) begin
                    n_state = ST_OUT;
                    if ($signed(r_pos) >= $signed(lim_value)) begin
                        n_mode  = MOTOR_HALT;
                        n_fresh = 1'b1;
                        n_phase = PH_WAIT;
                    end
                end
            end
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mode    <= MOTOR_HALT;
            r_pos     <= '0;
            r_end     <= '0;
            r_head    <= 1'b0;
            r_dir     <= 1'b0;
            r_step    <= 1'b0;
            r_phase   <= PH_HOME;
            r_fresh   <= 1'b1;
            r_run     <= 1'b0;
            r_taken   <= '0;
            r_elapsed <= '0;
            r_shutter <= 1'b0;
            r_rej     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_pos     <= n_pos;
            r_end     <= n_end;
            r_head    <= n_head;
            r_dir     <= n_dir;
            r_step    <= n_step;
            r_phase   <= n_phase;
            r_fresh   <= n_fresh;
            r_run     <= n_run;
            r_taken   <= n_taken;
            r_elapsed <= n_elapsed;
            r_shutter <= n_shutter;
            r_rej     <= n_rej;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exposure <= EXPOSURE_RST;
            r_offset   <= OFFSET_RST;
            r_pictures <= PICTURES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXPOSURE: r_exposure <= i_cfg_data;
                CFG_OFFSET:   r_offset   <= i_cfg_data;
                CFG_PICTURES: r_pictures <= i_cfg_data;
                default:      r_offset   <= r_offset;
            endcase
        end
    end

    // result straight from the state registers, which hold while it waits
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        o_out                = '0;
        o_out.step_level     = r_step;
        o_out.dir_level      = r_dir;
        o_out.shutter_active = r_shutter;
        o_out.motor_mode     = r_mode;
        o_out.position       = 32'($signed(r_pos));
        o_out.seq_running    = r_run;
        o_out.pictures_done  = r_taken;
        o_out.rejected       = r_rej;
    end

endmodule

// ===== design/ssms_limit_unit.sv =====
`timescale 1ns / 1ps

// limit = trunc(end / divisor) * taken, all wrapping at POS_BITS,
// computed on one shared adder: negate, restoring divide, negate, shift-add multiply
module ssms_limit_unit
    import ssms_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [POS_BITS-1:0] i_end,
    input  logic [15:0]         i_divisor,
    input  logic [15:0]         i_taken,
    output logic                o_done,
    output logic [POS_BITS-1:0] o_limit
);

    localparam int AW = ((POS_BITS > 17) ? POS_BITS : 17) + 1;
    localparam int CW = $clog2(POS_BITS + 1);

    t_lstate             r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [15:0]         r_rem, n_rem;
    logic [POS_BITS-1:0] r_quo, n_quo;
    logic                r_neg, n_neg;
    logic [15:0]         r_d, n_d;
    logic [15:0]         r_mul, n_mul;
    logic [POS_BITS-1:0] r_acc, n_acc;
    logic [POS_BITS-1:0] r_mcand, n_mcand;

    logic [AW-1:0] add_a, add_b, add_sum;
    logic          add_cin;
    logic [16:0]   div_shift;
    logic          div_ge;

    // shared adder operand select
    always_comb begin
        div_shift = {r_rem, r_quo[POS_BITS-1]};
        add_a     = '0;
        add_b     = '0;
        add_cin   = 1'b0;
        case (r_state)
            L_ABS, L_SIGN: begin
                add_b   = ~AW'(r_quo);
                add_cin = 1'b1;
            end
            L_DIV: begin
                add_a   = AW'(div_shift);
                add_b   = ~AW'(r_d);
                add_cin = 1'b1;
            end
            L_MUL: begin
                add_a = AW'(r_acc);
                add_b = AW'(r_mcand);
            end
            default: begin
                add_a = '0;
            end
        endcase
        add_sum = add_a + add_b + AW'(add_cin);
        div_ge  = ~add_sum[AW-1];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_neg   = r_neg;
        n_d     = r_d;
        n_mul   = r_mul;
        n_acc   = r_acc;
        n_mcand = r_mcand;
        o_done  = 1'b0;
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    n_quo   = i_end;
                    n_neg   = i_end[POS_BITS-1];
                    n_d     = i_divisor;
                    n_mul   = i_taken;
                    n_rem   = '0;
                    n_cnt   = CW'(POS_BITS);
                    n_state = i_end[POS_BITS-1] ? L_ABS : L_DIV;
                end
            end
            L_ABS: begin
                n_quo   = add_sum[POS_BITS-1:0];
                n_state = L_DIV;
            end
            L_DIV: begin
                n_rem = div_ge ? add_sum[15:0] : div_shift[15:0];
                n_quo = {r_quo[POS_BITS-2:0], div_ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = L_SIGN;
                end
            end
            L_SIGN: begin
                // zero divisor gives a zero quotient
                if (r_d == '0) begin
                    n_mcand = '0;
                end else if (r_neg) begin
                    n_mcand = add_sum[POS_BITS-1:0];
                end else begin
                    n_mcand = r_quo;
                end
                n_acc   = '0;
                n_cnt   = CW'(16);
                n_state = L_MUL;
            end
            L_MUL: begin
                if (r_mul[0]) begin
                    n_acc = add_sum[POS_BITS-1:0];
                end
                n_mcand = {r_mcand[POS_BITS-2:0], 1'b0};
                n_mul   = {1'b0, r_mul[15:1]};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = L_DONE;
                end
            end
            L_DONE: begin
                o_done  = 1'b1;
                n_state = L_IDLE;
            end
            default: begin
                n_state = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_neg   <= n_neg;
        r_d     <= n_d;
        r_mul   <= n_mul;
        r_acc   <= n_acc;
        r_mcand <= n_mcand;
    end

    assign o_limit = r_acc;

endmodule
